@@ sv/tme_pkg.sv @@
`timescale 1ns / 1ps
package tme_pkg;
  typedef enum logic [3:0] {
    K_ADD = 4'd0, K_SET = 4'd1, K_MOVE = 4'd2, K_JZ = 4'd3, K_JNZ = 4'd4,
    K_PUT = 4'd5, K_GET = 4'd6, K_CLEAR = 4'd7, K_MULCOPY = 4'd8,
    K_SCANR = 4'd9, K_SCANL = 4'd10, K_END = 4'd11
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_BEFORE = 2'd1, ST_BEYOND = 2'd2, ST_HALTED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_READ2, S_EXEC, S_SCAN
  } state_e;

  localparam logic [0:0] REG_EOF_MODE = 1'b0;
  localparam logic [0:0] REG_INIT_PTR = 1'b1;
  localparam logic [1:0] EOF_ZERO = 2'd1;
  localparam logic [1:0] EOF_FULL = 2'd2;
  localparam int unsigned FULL_CHAR = 255;
endpackage

@@ sv/tape_machine_execute_unit.sv @@
`timescale 1ns / 1ps
// Tape machine execute unit.
// Instruction words enter on start while busy is low; each yields exactly one
// result word, shown for one cycle with done_o high. The receiver cannot stall.
// Configuration words (index 0 eof mode, 1 initial pointer) are taken on
// cfg_valid_i when cfg_ready_o is high; writing the initial pointer also loads
// the data pointer.
// The tape lives in one synchronous single-port memory with a registered read.
// Pointer moves, end, unused kinds and address errors finish in the read state;
// cell operations read, then modify and write in the execute state; branch tests
// read, then test; mulcopy reads both cells before executing. A scan reads one cell
// per step in the scan state until it finds a zero cell or leaves the tape. The
// next word can be accepted in the cycle that shows the previous result.
// After reset a clearing pass writes zero to every cell with busy high;
// configuration writes are accepted during that pass.
// Once an error or end instruction halts the unit, every later word reports the
// halted status until reset.
module tape_machine_execute_unit #(
  parameter int unsigned TAPE_CELLS = 65536,
  parameter int unsigned CELL_BITS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  kind_i,
  input  logic signed [31:0] amount_i,
  input  logic signed [15:0] cell_offset_i,
  input  logic signed [15:0] factor_i,
  input  logic [7:0]  in_char_i,
  input  logic        in_eof_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        done_o,
  output logic        out_valid_o,
  output logic [7:0]  out_char_o,
  output logic [30:0] out_repeat_o,
  output logic        branch_taken_o,
  output logic [15:0] pointer_o,
  output logic [1:0]  status_o
);
  import tme_pkg::*;

  localparam int unsigned AW = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;
  localparam int unsigned PW = AW + 1;
  localparam logic [PW-1:0] LAST = PW'(TAPE_CELLS - 1);

  logic [CELL_BITS-1:0] mem_q [TAPE_CELLS];
  logic [CELL_BITS-1:0] rdata_q;
  logic [CELL_BITS-1:0] cella_q, cella_d;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [CELL_BITS-1:0] wdata;
  logic        re;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  state_e state_q, state_d;
  logic [PW-1:0] clr_q, clr_d;
  logic [PW-1:0] ptr_q, ptr_d;
  logic        halted_q, halted_d;
  logic [1:0]  eof_q, eof_d;
  logic [3:0]  kind_q, kind_d;
  logic signed [31:0] amt_q, amt_d;
  logic signed [15:0] off_q, off_d, fac_q, fac_d;
  logic [7:0]  ch_q, ch_d;
  logic        eofin_q, eofin_d;
  logic [AW-1:0] a_q, a_d, b_q, b_d;
  logic [PW-1:0] x_q, x_d;
  logic [31:0] stride_q, stride_d;

  logic        done_d;
  logic        ov_d, bt_d;
  logic [7:0]  oc_d;
  logic [30:0] orep_d;
  logic [1:0]  ost_d;

  logic signed [33:0] pa, pb, pm;
  logic [1:0]  sa, sb, sm;
  logic signed [33:0] xn_r, xn_l;
  logic [CELL_BITS-1:0] prod;

  function automatic logic [1:0] rng(input logic signed [33:0] p);
    if (p < 0) begin
      return ST_BEFORE;
    end else if (p > $signed({1'b0, 33'(TAPE_CELLS - 1)})) begin
      return ST_BEYOND;
    end else begin
      return ST_OK;
    end
  endfunction

  assign busy = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    pa = $signed({1'b0, 33'(ptr_q)}) + 34'(off_q);
    pb = pa + 34'(amt_q);
    pm = $signed({1'b0, 33'(ptr_q)}) + 34'(amt_q);
    sa = rng(pa);
    sb = rng(pb);
    sm = rng(pm);
    xn_r = $signed({1'b0, 33'(x_q)}) + $signed({2'b0, stride_q});
    xn_l = $signed({1'b0, 33'(x_q)}) - $signed({2'b0, stride_q});
    prod = CELL_BITS'(cella_q * CELL_BITS'(fac_q));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == LAST) state_d = S_IDLE;
      S_IDLE: if (start) state_d = S_READ;
      S_READ: begin
        if (halted_q) begin
          state_d = S_IDLE;
        end else begin
          case (kind_q)
            K_ADD, K_SET, K_CLEAR, K_PUT, K_GET:
              state_d = (sa == ST_OK) ? S_EXEC : S_IDLE;
            K_MULCOPY:
              state_d = (sa == ST_OK && sb == ST_OK) ? S_READ2 : S_IDLE;
            K_JZ, K_JNZ: state_d = S_EXEC;
            K_SCANR, K_SCANL: state_d = S_SCAN;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_READ2: state_d = S_EXEC;
      S_EXEC: state_d = S_IDLE;
      S_SCAN: begin
        if (rdata_q == '0) begin
          state_d = S_IDLE;
        end else if (kind_q == K_SCANR) begin
          if (xn_r > $signed({1'b0, 33'(LAST)})) state_d = S_IDLE;
        end else if (xn_l < 0) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    clr_d = clr_q; ptr_d = ptr_q; halted_d = halted_q; eof_d = eof_q;
    kind_d = kind_q; amt_d = amt_q; off_d = off_q; fac_d = fac_q;
    ch_d = ch_q; eofin_d = eofin_q; a_d = a_q; b_d = b_q;
    x_d = x_q; stride_d = stride_q; cella_d = cella_q;
    we = 1'b0; waddr = '0; wdata = '0; re = 1'b0; raddr = '0;
    done_d = 1'b0; ov_d = 1'b0; oc_d = '0; orep_d = '0; bt_d = 1'b0; ost_d = ST_OK;

    if (cfg_valid_i) begin
      if (cfg_index_i == REG_EOF_MODE) begin
        eof_d = cfg_data_i[1:0];
      end else begin
        ptr_d = ({1'b0, 16'(cfg_data_i)} > 17'(TAPE_CELLS - 1)) ? LAST
                : PW'(cfg_data_i);
      end
    end

    case (state_q)
      S_CLEAR: begin
        we = 1'b1; waddr = clr_q[AW-1:0]; wdata = '0;
        clr_d = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (start) begin
          kind_d = kind_i; amt_d = amount_i; off_d = cell_offset_i;
          fac_d = factor_i; ch_d = in_char_i; eofin_d = in_eof_i;
          stride_d = (amount_i == 0) ? 32'd1 : amount_i;
          x_d = ptr_q;
        end
      end
      S_READ: begin
        a_d = pa[AW-1:0];
        b_d = pb[AW-1:0];
        re = 1'b1;
        raddr = (kind_q == K_JZ || kind_q == K_JNZ || kind_q == K_SCANR ||
                 kind_q == K_SCANL) ? ptr_q[AW-1:0] : pa[AW-1:0];
        if (halted_q) begin
          done_d = 1'b1; ost_d = ST_HALTED;
        end else begin
          case (kind_q)
            K_ADD, K_SET, K_CLEAR, K_PUT, K_GET: begin
              if (sa != ST_OK) begin
                done_d = 1'b1; ost_d = sa; halted_d = 1'b1;
              end
            end
            K_MULCOPY: begin
              if (sa != ST_OK || sb != ST_OK) begin
                done_d = 1'b1; ost_d = (sa != ST_OK) ? sa : sb; halted_d = 1'b1;
              end
            end
            K_MOVE: begin
              done_d = 1'b1; ost_d = sm;
              if (sm == ST_OK) ptr_d = pm[PW-1:0];
              else halted_d = 1'b1;
            end
            K_END: begin
              done_d = 1'b1; ost_d = ST_HALTED; halted_d = 1'b1;
            end
            K_JZ, K_JNZ, K_SCANR, K_SCANL: ;
            default: done_d = 1'b1;
          endcase
        end
      end
      S_READ2: begin
        cella_d = rdata_q;
        re = 1'b1; raddr = b_q;
      end
      S_EXEC: begin
        done_d = 1'b1;
        case (kind_q)
          K_ADD: begin
            we = 1'b1; waddr = a_q; wdata = rdata_q + CELL_BITS'(amt_q);
          end
          K_SET: begin
            we = 1'b1; waddr = a_q; wdata = CELL_BITS'(amt_q);
          end
          K_CLEAR: begin
            we = 1'b1; waddr = a_q; wdata = '0;
          end
          K_GET: begin
            waddr = a_q;
            if (!eofin_q) begin
              we = 1'b1; wdata = CELL_BITS'(ch_q);
            end else if (eof_q == EOF_ZERO) begin
              we = 1'b1; wdata = '0;
            end else if (eof_q == EOF_FULL) begin
              we = 1'b1; wdata = CELL_BITS'(FULL_CHAR);
            end
          end
          K_PUT: begin
            if (amt_q > 0) begin
              ov_d = 1'b1; oc_d = rdata_q[7:0]; orep_d = amt_q[30:0];
            end
          end
          K_MULCOPY: begin
            we = 1'b1; waddr = b_q; wdata = rdata_q + prod;
          end
          K_JZ: bt_d = (rdata_q == '0);
          K_JNZ: bt_d = (rdata_q != '0);
          default: ;
        endcase
      end
      S_SCAN: begin
        if (rdata_q == '0) begin
          done_d = 1'b1; ptr_d = x_q;
        end else if (kind_q == K_SCANR) begin
          if (xn_r > $signed({1'b0, 33'(LAST)})) begin
            done_d = 1'b1; ptr_d = LAST; ost_d = ST_BEYOND; halted_d = 1'b1;
          end else begin
            x_d = xn_r[PW-1:0]; re = 1'b1; raddr = xn_r[AW-1:0];
          end
        end else begin
          if (xn_l < 0) begin
            done_d = 1'b1; ptr_d = '0; ost_d = ST_BEFORE; halted_d = 1'b1;
          end else begin
            x_d = xn_l[PW-1:0]; re = 1'b1; raddr = xn_l[AW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      ptr_q <= '0;
      halted_q <= 1'b0;
      eof_q <= '0;
      done_o <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      ptr_q <= ptr_d;
      halted_q <= halted_d;
      eof_q <= eof_d;
      done_o <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d; amt_q <= amt_d; off_q <= off_d; fac_q <= fac_d;
    ch_q <= ch_d; eofin_q <= eofin_d; a_q <= a_d; b_q <= b_d;
    x_q <= x_d; stride_q <= stride_d; cella_q <= cella_d;
    out_valid_o <= ov_d; out_char_o <= oc_d; out_repeat_o <= orep_d;
    branch_taken_o <= bt_d; status_o <= ost_d;
  end

  assign pointer_o = 16'(ptr_q);
endmodule

@@ sv/tme_checker.sv @@
`timescale 1ns / 1ps
module tme_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic       out_valid_o,
  input logic [1:0] status_o
);
  import tme_pkg::*;

  a_done_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without work in flight");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");

  a_put_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_valid_o) |-> status_o == ST_OK) else $error("emit with error");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
endmodule

bind tape_machine_execute_unit tme_checker u_tme_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done_o(done_o),
  .out_valid_o(out_valid_o), .status_o(status_o)
);
